// ===== sv/tvd_slope_limiter_core_defines.svh =====
// Assertion macros shared by the slope limiter RTL.
`ifndef TVD_SLOPE_LIMITER_CORE_DEFINES_SVH
`define TVD_SLOPE_LIMITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TVD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("slope limiter check failed");
`define TVD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slope limiter check failed");
`else
`define TVD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define TVD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tvd_pkg.sv =====
// Package with limiter mode codes and pipeline sideband type.
package tvd_pkg;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_MINMOD = 2'd1;
    localparam logic [1:0] MODE_MC     = 2'd2;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic active;
        logic bad;
        logic mc_mode;
        logic neg_l;
        logic neg_r;
        logic neg_c;
    } t_side;

endpackage

// ===== sv/tvd_slope_limiter_core.sv =====
// Pipelined minmod / monotonized-central slope limiter for a non-uniform 1-D grid.
// An accepted start passes the entry register, the divide stages, the limiter stage and the output register to o_valid.
// Throughput: one transaction per cycle; busy is always low and every stage advances each cycle.
// The three quotients come from restoring dividers, one quotient bit per pipeline stage.
// Reset (synchronous, active low) clears r_mode to 0 and drops every in-flight transaction.
`include "tvd_slope_limiter_core_defines.svh"

module tvd_slope_limiter_core
    import tvd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_val_left,
    input  logic signed [31:0] i_val_center,
    input  logic signed [31:0] i_val_right,
    input  logic signed [31:0] i_pos_left,
    input  logic signed [31:0] i_pos_center,
    input  logic signed [31:0] i_pos_right,
    input  logic               i_has_left,
    input  logic               i_has_right,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_slope,
    output logic               o_overflowed,
    output logic               o_bad_spacing
);

    // Dividend is |dv| << FRAC_BITS; the quotient has as many bits.
    localparam int N = 32 + FRAC_BITS;

    // The block never stalls, and configuration is always taken.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [1:0] r_mode;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Entry stage: exact 33-bit differences, magnitudes, spacing check.
    logic signed [32:0] n_dl, n_dr, n_dc, n_xl, n_xr, n_xc;
    logic [31:0]        n_al, n_ar, n_ac;
    t_side              n_side;

    always_comb begin
        n_dl = {i_val_center[31], i_val_center} - {i_val_left[31], i_val_left};
        n_dr = {i_val_right[31], i_val_right} - {i_val_center[31], i_val_center};
        n_dc = {i_val_right[31], i_val_right} - {i_val_left[31], i_val_left};
        n_xl = {i_pos_center[31], i_pos_center} - {i_pos_left[31], i_pos_left};
        n_xr = {i_pos_right[31], i_pos_right} - {i_pos_center[31], i_pos_center};
        n_xc = {i_pos_right[31], i_pos_right} - {i_pos_left[31], i_pos_left};
        n_al = n_dl[32] ? 32'(-n_dl) : n_dl[31:0];
        n_ar = n_dr[32] ? 32'(-n_dr) : n_dr[31:0];
        n_ac = n_dc[32] ? 32'(-n_dc) : n_dc[31:0];
        n_side.active  = (r_mode == MODE_MINMOD || r_mode == MODE_MC)
                         && i_has_left && i_has_right;
        // Positions must be strictly increasing: both one-sided spans positive.
        n_side.bad     = n_xl[32] || (n_xl == 33'sd0) || n_xr[32] || (n_xr == 33'sd0);
        n_side.mc_mode = (r_mode == MODE_MC);
        n_side.neg_l   = n_dl[32];
        n_side.neg_r   = n_dr[32];
        n_side.neg_c   = n_dc[32];
    end

    // Divider pipeline: index 0 is the entry register, index N holds the quotients.
    // Remainder and divisor are only needed up to the last divide stage.
    logic        r_vld  [0:N];
    t_side       r_side [0:N];
    logic [31:0] r_rem  [0:N-1][0:2];
    logic [N-1:0] r_qd  [0:N][0:2];
    logic [31:0] r_dx   [0:N-1][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= start;
        end
        r_side[0]   <= n_side;
        r_rem[0][0] <= '0;
        r_rem[0][1] <= '0;
        r_rem[0][2] <= '0;
        r_qd[0][0]  <= {n_al, {FRAC_BITS{1'b0}}};
        r_qd[0][1]  <= {n_ar, {FRAC_BITS{1'b0}}};
        r_qd[0][2]  <= {n_ac, {FRAC_BITS{1'b0}}};
        r_dx[0][0]  <= n_xl[31:0];
        r_dx[0][1]  <= n_xr[31:0];
        r_dx[0][2]  <= n_xc[31:0];
    end

    // Each stage shifts one dividend bit into the remainder and resolves one quotient bit.
    // The dividend drains out of the top of r_qd while quotient bits fill in from the bottom.
    for (genvar k = 0; k < N; k++) begin : g_div
        for (genvar ln = 0; ln < 3; ln++) begin : g_lane
            logic [32:0] trial;
            logic        take;
            always_comb begin
                trial = {r_rem[k][ln], r_qd[k][ln][N-1]};
                take  = (trial >= {1'b0, r_dx[k][ln]});
            end
            always_ff @(posedge i_clk) begin
                r_qd[k+1][ln] <= {r_qd[k][ln][N-2:0], take};
            end
            if (k < N - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_rem[k+1][ln] <= take ? 32'(trial - {1'b0, r_dx[k][ln]}) : trial[31:0];
                    r_dx[k+1][ln]  <= r_dx[k][ln];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_side[k+1] <= r_side[k];
        end
    end

    // Limiter stage: an inactive item, bad spacing, or a zero or sign-changing one-sided quotient kills the slope;
    // otherwise take the smallest of the (optionally doubled) one-sided and central magnitudes.
    logic [N-1:0] w_ql, w_qr, w_qc;
    logic [N:0]   n_sl, n_sr, n_min_lr, n_min;
    logic         n_keep;

    always_comb begin
        w_ql     = r_qd[N][0];
        w_qr     = r_qd[N][1];
        w_qc     = r_qd[N][2];
        n_sl     = r_side[N].mc_mode ? {w_ql, 1'b0} : {1'b0, w_ql};
        n_sr     = r_side[N].mc_mode ? {w_qr, 1'b0} : {1'b0, w_qr};
        n_min_lr = (n_sl < n_sr) ? n_sl : n_sr;
        n_min    = (n_min_lr < {1'b0, w_qc}) ? n_min_lr : {1'b0, w_qc};
        n_keep   = r_side[N].active && !r_side[N].bad && (w_ql != '0) && (w_qr != '0)
                   && (r_side[N].neg_l == r_side[N].neg_r);
    end

    logic       r_lim_vld;
    logic [N:0] r_lim_mag;
    logic       r_lim_keep, r_lim_neg, r_lim_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_vld <= 1'b0;
        end else begin
            r_lim_vld <= r_vld[N];
        end
        r_lim_mag  <= n_min;
        r_lim_keep <= n_keep;
        r_lim_neg  <= r_side[N].neg_c;
        r_lim_bad  <= r_side[N].active && r_side[N].bad;
    end

    // Saturation stage: clamp the signed magnitude to the 32-bit range and flag it.
    logic [31:0] n_slope;
    logic        n_ovf;

    always_comb begin
        n_slope = '0;
        n_ovf   = 1'b0;
        if (r_lim_keep) begin
            if (r_lim_neg) begin
                if (r_lim_mag > (N+1)'(SAT_NEG)) begin
                    n_slope = SAT_NEG;
                    n_ovf   = 1'b1;
                end else begin
                    n_slope = 32'(-r_lim_mag);
                end
            end else begin
                if (r_lim_mag > (N+1)'(SAT_POS)) begin
                    n_slope = SAT_POS;
                    n_ovf   = 1'b1;
                end else begin
                    n_slope = r_lim_mag[31:0];
                end
            end
        end
    end

    logic        r_out_vld;
    logic [31:0] r_out_slope;
    logic        r_out_ovf, r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_lim_vld;
        end
        r_out_slope <= n_slope;
        r_out_ovf   <= n_ovf;
        r_out_bad   <= r_lim_bad;
    end

    assign o_valid       = r_out_vld;
    assign o_slope       = $signed(r_out_slope);
    assign o_overflowed  = r_out_ovf;
    assign o_bad_spacing = r_out_bad;

    // A flagged spacing error always comes with a zero slope and no overflow.
    `TVD_ASSERT_IMPLY(a_bad_zero, i_clk, i_rst_n,
                      o_valid && o_bad_spacing,
                      (o_slope == 32'sd0) && !o_overflowed)
    // An overflow leaves the slope pinned at one of the two saturation limits.
    `TVD_ASSERT_IMPLY(a_ovf_limit, i_clk, i_rst_n,
                      o_valid && o_overflowed,
                      (r_out_slope == SAT_POS) || (r_out_slope == SAT_NEG))
    // The limiter stage's strobe reaches the output in the next cycle.
    `TVD_ASSERT_IMPLY(a_out_follows, i_clk, i_rst_n,
                      r_lim_vld && $past(i_rst_n), ##1 o_valid)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the minmod / monotonized-central slope limiter core.
`timescale 1ns / 1ps

module testbench
    import tvd_pkg::*;
();

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 32 + FRAC_BITS + 3;
    localparam longint MAX_CYCLES = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_val_left, i_val_center, i_val_right;
    logic signed [31:0] i_pos_left, i_pos_center, i_pos_right;
    logic               i_has_left, i_has_right;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_data;
    logic               o_valid;
    logic signed [31:0] o_slope;
    logic               o_overflowed;
    logic               o_bad_spacing;

    typedef struct packed {
        logic [31:0] slope;
        logic        ovf;
        logic        bad;
    } t_slope_res;

    t_slope_res  slope_queue[$];
    logic [1:0]  mode_shadow;
    int          mismatches;
    longint      cycles;
    bit          idle_enable;

    tvd_slope_limiter_core #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_val_left(i_val_left), .i_val_center(i_val_center),
        .i_val_right(i_val_right), .i_pos_left(i_pos_left),
        .i_pos_center(i_pos_center), .i_pos_right(i_pos_right),
        .i_has_left(i_has_left), .i_has_right(i_has_right),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_slope(o_slope),
        .o_overflowed(o_overflowed), .o_bad_spacing(o_bad_spacing)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Magnitude of a quotient dv/dx in fixed point, truncated; dx is positive.
    function automatic logic [63:0] quot_mag(logic signed [32:0] dv, logic signed [32:0] dx);
        logic [63:0] mag;
        mag = dv[32] ? 64'(-65'(dv)) : 64'(dv);
        return (mag << FRAC_BITS) / 64'(dx);
    endfunction

    // Predicts the slope result for one item under the current limiter mode.
    function automatic t_slope_res predict_slope(
        logic signed [31:0] vl, logic signed [31:0] vc, logic signed [31:0] vr,
        logic signed [31:0] pl, logic signed [31:0] pc, logic signed [31:0] pr,
        logic hl, logic hr);
        t_slope_res        r;
        logic signed [32:0] dl, dr, dc;
        logic [63:0]        ml, mr, mc, m;
        r = '0;
        if ((mode_shadow == MODE_MINMOD || mode_shadow == MODE_MC) && hl && hr) begin
            if (!(pc > pl && pr > pc)) begin
                r.bad = 1'b1;
            end else begin
                dl = 33'(vc) - 33'(vl);
                dr = 33'(vr) - 33'(vc);
                dc = 33'(vr) - 33'(vl);
                ml = quot_mag(dl, 33'(pc) - 33'(pl));
                mr = quot_mag(dr, 33'(pr) - 33'(pc));
                mc = quot_mag(dc, 33'(pr) - 33'(pl));
                if (ml != 0 && mr != 0 && dl[32] == dr[32]) begin
                    if (mode_shadow == MODE_MC) begin
                        ml = ml << 1;
                        mr = mr << 1;
                    end
                    m = (ml < mr) ? ml : mr;
                    m = (m < mc) ? m : mc;
                    if (dc[32]) begin
                        if (m > 64'h8000_0000) begin
                            m = 64'h8000_0000;
                            r.ovf = 1'b1;
                        end
                        r.slope = 32'(-m);
                    end else begin
                        if (m > 64'h7FFF_FFFF) begin
                            m = 64'h7FFF_FFFF;
                            r.ovf = 1'b1;
                        end
                        r.slope = m[31:0];
                    end
                end
            end
        end
        return r;
    endfunction

    // Result checker: every strobe is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_slope_res exp_r;
        if (i_rst_n && o_valid) begin
            if (slope_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: slope %h ovf %b bad %b",
                             o_slope, o_overflowed, o_bad_spacing);
            end else begin
                exp_r = slope_queue.pop_front();
                if (o_slope !== exp_r.slope || o_overflowed !== exp_r.ovf ||
                    o_bad_spacing !== exp_r.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected slope %h ovf %b bad %b, got %h %b %b",
                                 exp_r.slope, exp_r.ovf, exp_r.bad,
                                 o_slope, o_overflowed, o_bad_spacing);
                end
            end
        end
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    // Start drops only when the sender actually idles, so back-to-back items keep it high.
    task automatic random_gap();
        int n;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sends one transaction and records its predicted result.
    task automatic send_item(logic [31:0] vl, logic [31:0] vc, logic [31:0] vr,
                             logic [31:0] pl, logic [31:0] pc, logic [31:0] pr,
                             logic hl, logic hr);
        random_gap();
        start        <= 1'b1;
        i_val_left   <= vl;
        i_val_center <= vc;
        i_val_right  <= vr;
        i_pos_left   <= pl;
        i_pos_center <= pc;
        i_pos_right  <= pr;
        i_has_left   <= hl;
        i_has_right  <= hr;
        do @(posedge i_clk); while (busy);
        slope_queue.push_back(predict_slope(vl, vc, vr, pl, pc, pr, hl, hr));
    endtask

    // Waits for every prediction to be matched, then lets the pipe drain.
    task automatic drain();
        start <= 1'b0;
        while (slope_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] mode);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_shadow = mode;
    endtask

    task automatic test_directed_edges();
        logic [1:0] mode;
        for (int k = 0; k < 4; k++) begin
            mode = 2'(k);
            write_mode(mode);
            // Smooth ramp, then the boundaries.
            send_item(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                      32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1, 1);
            send_item(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                      32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 0, 1);
            send_item(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                      32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1, 0);
            // Non-increasing positions.
            send_item(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1, 1);
            send_item(32'h0, 32'h1, 32'h2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1);
            // Local extremum and a flat side.
            send_item(32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000,
                      32'h0002_0000, 1, 1);
            send_item(32'h0003_0000, 32'h0003_0000, 32'h0006_0000, 32'h0,
                      32'h0001_0000, 32'h0002_0000, 1, 1);
            // Extreme values on a tight grid: saturates both ways.
            send_item(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0001, 32'h8000_0002, 1, 1);
            send_item(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFD,
                      32'h7FFF_FFFE, 32'h7FFF_FFFF, 1, 1);
            // Widest grid, tiny differences truncate to zero.
            send_item(32'h0, 32'h1, 32'h2, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1, 1);
        end
    endtask

    // Random items: mostly well-formed increasing grids, some noise.
    task automatic test_random(int count);
        logic [31:0] v[3];
        logic [31:0] p[3];
        logic        hl, hr;
        int          kind;
        for (int i = 0; i < count; i++) begin
            if (i % 300 == 0)
                write_mode(2'($urandom_range(0, 3)));
            if (i == count / 2)
                drain();
            if (i == count - 200)
                idle_enable = 1'b0;
            kind = $urandom_range(0, 9);
            hl = ($urandom_range(0, 15) != 0);
            hr = ($urandom_range(0, 15) != 0);
            if (kind == 0) begin
                foreach (v[j]) v[j] = $urandom();
                foreach (p[j]) p[j] = $urandom();
            end else begin
                p[0] = $urandom();
                p[0] = {p[0][31], p[0][31], p[0][29:0]};
                p[1] = p[0] + ((kind < 5) ? $urandom_range(1, 32'h0004_0000)
                                          : ($urandom() >> $urandom_range(2, 31)) + 1);
                p[2] = p[1] + ((kind < 5) ? $urandom_range(1, 32'h0004_0000)
                                          : ($urandom() >> $urandom_range(2, 31)) + 1);
                v[1] = $urandom();
                if (kind < 8) begin
                    v[0] = v[1] - ($urandom() >> $urandom_range(0, 31));
                    v[2] = v[1] + ($urandom() >> $urandom_range(0, 31));
                    if (kind[0]) begin
                        v[0] = v[1] + (v[1] - v[0]);
                        v[2] = v[1] - (v[2] - v[1]);
                    end
                end else begin
                    v[0] = $urandom();
                    v[2] = $urandom();
                end
            end
            send_item(v[0], v[1], v[2], p[0], p[1], p[2], hl, hr);
        end
    endtask

    initial begin
        start        <= 1'b0;
        i_val_left   <= '0;
        i_val_center <= '0;
        i_val_right  <= '0;
        i_pos_left   <= '0;
        i_pos_center <= '0;
        i_pos_right  <= '0;
        i_has_left   <= 1'b0;
        i_has_right  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= MODE_OFF;
        i_rst_n      <= 1'b0;
        mode_shadow  = MODE_OFF;
        mismatches   = 0;
        cycles       = 0;
        idle_enable  = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        write_mode(MODE_MC);
        test_random(1800);
        drain();

        if (mismatches == 0 && slope_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tvd_pkg.sv
sv/tvd_slope_limiter_core.sv
tb/testbench.sv
